// ----- hw/rtl/rvp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvp_pkg: shared definitions for the region variation priority block
// Widths, operation codes and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rvp_pkg;

    // Default number of samples in one region.
    localparam int POINTS_DEF = 9;

    // Field and internal widths.
    localparam int DATA_W = 32;
    localparam int SUM_W  = 40;
    localparam int ACC_W  = 71;
    localparam int DIV_NW = 80;
    localparam int DIV_DW = 40;

    // Reset value of the domain size register (1.0 in Q16.16).
    localparam logic [DATA_W-1:0] DOMAIN_RESET = 32'h0001_0000;

    // Datapath operation codes.
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
    localparam logic [OP_W-1:0] OP_MEAN_GO   = 5'd2;
    localparam logic [OP_W-1:0] OP_MEAN_TAKE = 5'd3;
    localparam logic [OP_W-1:0] OP_ZERO      = 5'd4;
    localparam logic [OP_W-1:0] OP_RD        = 5'd5;
    localparam logic [OP_W-1:0] OP_DEV       = 5'd6;
    localparam logic [OP_W-1:0] OP_SQ        = 5'd7;
    localparam logic [OP_W-1:0] OP_ACC       = 5'd8;
    localparam logic [OP_W-1:0] OP_VAR_ZERO  = 5'd9;
    localparam logic [OP_W-1:0] OP_VAR_GO    = 5'd10;
    localparam logic [OP_W-1:0] OP_VAR_TAKE  = 5'd11;
    localparam logic [OP_W-1:0] OP_SQRT      = 5'd12;
    localparam logic [OP_W-1:0] OP_NUM       = 5'd13;
    localparam logic [OP_W-1:0] OP_DEN       = 5'd14;
    localparam logic [OP_W-1:0] OP_CV_GO     = 5'd15;
    localparam logic [OP_W-1:0] OP_CV_TAKE   = 5'd16;
    localparam logic [OP_W-1:0] OP_ABS       = 5'd17;
    localparam logic [OP_W-1:0] OP_PSAT      = 5'd18;
    localparam logic [OP_W-1:0] OP_AA        = 5'd19;
    localparam logic [OP_W-1:0] OP_LO        = 5'd20;
    localparam logic [OP_W-1:0] OP_HI        = 5'd21;
    localparam logic [OP_W-1:0] OP_P_GO      = 5'd22;
    localparam logic [OP_W-1:0] OP_P_TAKE    = 5'd23;
    localparam logic [OP_W-1:0] OP_OUT       = 5'd24;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic [OP_W-1:0] op;
    } rvp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_full;
        logic idx_last;
        logic single;
        logic mean_zero;
        logic sqrt_last;
        logic prio_sat;
        logic out_free;
        logic div_done;
    } rvp_stat_t;

endpackage

// ----- hw/rtl/rvp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rvp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/rvp_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvp_div: radix-2 restoring divider
// Unsigned 80 by 40 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rvp_div
    import rvp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic [DIV_NW-1:0] quotient,
    output logic              done
);

    localparam int CNT_W = $clog2(DIV_NW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_NW - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_NW-1:0] sh_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dvs_reg;

    logic [DIV_DW:0]   trial;
    logic              ge;
    logic [DIV_DW:0]   diff;

    // Trial subtraction for one quotient bit.
    always_comb
    begin
        trial = {rem_reg, sh_reg[DIV_NW-1]};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift register that turns from dividend into quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[DIV_NW-2:0], ge};
            rem_reg <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        end
    end

    assign quotient = sh_reg;
    assign done     = done_reg;

`ifndef NO_ASSERTIONS
    // A new division is never started on top of one in flight.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
`endif

endmodule

// ----- hw/rtl/rvp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvp_datapath: sample store, statistics arithmetic and output register
// Holds the region state and carries out one operation per command.
// ----------------------------------------------------------------------------
module rvp_datapath
    import rvp_pkg::*;
#(
    parameter int POINTS = POINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rvp_cmd_t           cmd,
    output rvp_stat_t          st,
    input  logic [63:0]        s_tdata,
    input  logic               cfg_wr_en,
    input  logic [DATA_W-1:0]  cfg_wr_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,
    output logic [0:0]         m_tuser
);

    localparam int CW = $clog2(POINTS + 1);
    localparam int AW = $clog2(POINTS);

    // Region state.
    logic [DATA_W-1:0]        domain_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [CW-1:0]            count_reg;
    logic [DATA_W-1:0]        cell_reg;

    // Working registers.
    logic [AW-1:0]            idx_reg;
    logic signed [DATA_W-1:0] mean_reg;
    logic [DATA_W-1:0]        mag_reg;
    logic                     neg_reg;
    logic [DATA_W-1:0]        dev_reg;
    logic [63:0]              prod_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [63:0]              x_reg;
    logic [63:0]              r_reg;
    logic [63:0]              bit_reg;
    logic [40:0]              num_reg;
    logic [DATA_W-1:0]        cv_reg;
    logic                     sat_reg;
    logic [DATA_W-1:0]        a_reg;
    logic [63:0]              aa_reg;
    logic [63:0]              pp_reg;
    logic [DATA_W-1:0]        prio_reg;
    logic                     zm_reg;

    // Output register.
    logic                     m_tvalid_reg;
    logic [63:0]              m_tdata_reg;
    logic                     m_tuser_reg;

    // Shared units.
    logic                     div_start;
    logic [DIV_NW-1:0]        div_n;
    logic [DIV_DW-1:0]        div_d;
    logic [DIV_NW-1:0]        div_q;
    logic                     div_done;
    logic [DATA_W-1:0]        ram_rdata;
    logic                     ram_we;

    logic [DATA_W-1:0]        mul_a;
    logic [DATA_W-1:0]        mul_b;
    logic [63:0]              mul_p;

    logic [SUM_W-1:0]         sum_abs;
    logic [CW+1:0]            n4;
    logic [CW+1:0]            n4p1;
    logic [CW-1:0]            n_m1;
    logic [DATA_W:0]          dev_diff;
    logic [63:0]              rb;
    logic                     sq_ge;
    logic [95:0]              pwide;
    logic                     cv_pos_sat;
    logic                     cv_neg_sat;
    logic [DATA_W-1:0]        cv_val;
    logic [DATA_W:0]          cv_plus;
    logic [DATA_W:0]          cv_abs;
    logic [63:0]              var_val;

    rvp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata[DATA_W-1:0]),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    rvp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_q),
        .done     (div_done)
    );

    // Derived values used by several operations.
    always_comb
    begin
        ram_we   = cmd.op == OP_LOAD;
        sum_abs  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        n4       = {count_reg, 2'b00};
        n4p1     = {count_reg, 2'b01};
        n_m1     = count_reg - 1'b1;
        dev_diff = {ram_rdata[DATA_W-1], ram_rdata} - {mean_reg[DATA_W-1], mean_reg};
        rb       = r_reg + bit_reg;
        sq_ge    = x_reg >= rb;
        pwide    = {prod_reg, 32'b0} + {32'b0, pp_reg};
        var_val  = (div_q[DIV_NW-1:64] != '0) ? '1 : div_q[63:0];
        cv_pos_sat = |div_q[DIV_NW-1:31];
        cv_neg_sat = (|div_q[DIV_NW-1:32]) | (div_q[31] & (|div_q[30:0]));
        if (neg_reg)
        begin
            cv_val = cv_neg_sat ? 32'h8000_0000 : -div_q[DATA_W-1:0];
        end
        else
        begin
            cv_val = cv_pos_sat ? 32'h7FFF_FFFF : div_q[DATA_W-1:0];
        end
        cv_plus = {cv_reg[DATA_W-1], cv_reg} + 33'h0_0001_0000;
        cv_abs  = cv_plus[DATA_W] ? -cv_plus : cv_plus;
    end

    // Divider start and operand selection.
    always_comb
    begin
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        case (cmd.op)
            OP_MEAN_GO:
            begin
                div_start = 1'b1;
                div_n     = DIV_NW'(sum_abs);
                div_d     = DIV_DW'(count_reg);
            end
            OP_VAR_GO:
            begin
                div_start = 1'b1;
                div_n     = DIV_NW'(acc_reg);
                div_d     = DIV_DW'(n_m1);
            end
            OP_CV_GO:
            begin
                div_start = 1'b1;
                div_n     = DIV_NW'({num_reg, 16'b0});
                div_d     = prod_reg[DIV_DW-1:0];
            end
            OP_P_GO:
            begin
                div_start = 1'b1;
                div_n     = pwide[95:16];
                div_d     = DIV_DW'(domain_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Multiplier operand selection; one 32 by 32 product per cycle.
    always_comb
    begin
        case (cmd.op)
            OP_SQ:
            begin
                mul_a = dev_reg;
                mul_b = dev_reg;
            end
            OP_NUM:
            begin
                mul_a = r_reg[DATA_W-1:0];
                mul_b = DATA_W'(n4p1);
            end
            OP_DEN:
            begin
                mul_a = mag_reg;
                mul_b = DATA_W'(n4);
            end
            OP_AA:
            begin
                mul_a = a_reg;
                mul_b = a_reg;
            end
            OP_LO:
            begin
                mul_a = prod_reg[DATA_W-1:0];
                mul_b = cell_reg;
            end
            OP_HI:
            begin
                mul_a = aa_reg[63:32];
                mul_b = cell_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // Control state: domain register, running sum, count, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            domain_reg   <= DOMAIN_RESET;
            sum_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                domain_reg <= cfg_wr_data;
            end
            if (cmd.op == OP_LOAD)
            begin
                sum_reg   <= sum_reg + SUM_W'($signed(s_tdata[DATA_W-1:0]));
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.op == OP_OUT)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            if (cmd.op == OP_OUT)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, updated one operation at a time.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                if (count_reg == '0)
                begin
                    cell_reg <= s_tdata[63:32];
                end
            end
            OP_MEAN_TAKE:
            begin
                neg_reg  <= sum_reg[SUM_W-1];
                mag_reg  <= div_q[DATA_W-1:0];
                mean_reg <= sum_reg[SUM_W-1] ? -div_q[DATA_W-1:0] : div_q[DATA_W-1:0];
                zm_reg   <= div_q == '0;
                idx_reg  <= '0;
                acc_reg  <= '0;
            end
            OP_ZERO:
            begin
                prio_reg <= 32'hFFFF_FFFF;
                cv_reg   <= 32'h7FFF_FFFF;
            end
            OP_DEV:
            begin
                dev_reg <= dev_diff[DATA_W] ? DATA_W'(-dev_diff) : dev_diff[DATA_W-1:0];
            end
            OP_SQ, OP_NUM, OP_AA:
            begin
                prod_reg <= mul_p;
            end
            OP_ACC:
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
                idx_reg <= idx_reg + 1'b1;
            end
            OP_VAR_ZERO:
            begin
                x_reg   <= '0;
                r_reg   <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
            OP_VAR_TAKE:
            begin
                x_reg   <= var_val;
                r_reg   <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
            OP_SQRT:
            begin
                if (sq_ge)
                begin
                    x_reg <= x_reg - rb;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_DEN:
            begin
                num_reg  <= prod_reg[40:0];
                prod_reg <= mul_p;
            end
            OP_CV_TAKE:
            begin
                cv_reg  <= cv_val;
                sat_reg <= neg_reg ? cv_neg_sat : cv_pos_sat;
            end
            OP_ABS:
            begin
                a_reg <= cv_abs[DATA_W-1:0];
            end
            OP_PSAT:
            begin
                prio_reg <= 32'hFFFF_FFFF;
            end
            OP_LO:
            begin
                aa_reg   <= prod_reg;
                prod_reg <= mul_p;
            end
            OP_HI:
            begin
                pp_reg   <= prod_reg;
                prod_reg <= mul_p;
            end
            OP_P_TAKE:
            begin
                prio_reg <= (div_q[DIV_NW-1:32] != '0) ? 32'hFFFF_FFFF
                                                       : div_q[DATA_W-1:0];
            end
            OP_OUT:
            begin
                m_tdata_reg <= {cv_reg, prio_reg};
                m_tuser_reg <= zm_reg;
            end
            default:
            begin
                dev_reg <= dev_reg;
            end
        endcase
    end

    // Status toward the controller.
    always_comb
    begin
        st.count_full = count_reg == CW'(POINTS - 1);
        st.idx_last   = CW'(idx_reg) == n_m1;
        st.single     = count_reg == CW'(1);
        st.mean_zero  = div_q == '0;
        st.sqrt_last  = bit_reg[0];
        st.prio_sat   = sat_reg | (domain_reg == '0);
        st.out_free   = !m_tvalid_reg || m_tready;
        st.div_done   = div_done;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // The sample count never passes the region length.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(POINTS))
        else $error("sample count beyond region length");

    // A zero-mean word carries the saturated coefficient and priority.
    a_zero_mean_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 64'h7FFF_FFFF_FFFF_FFFF))
        else $error("zero-mean word without saturated values");

    // A result is only loaded when the output register can take it.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote a pending word");
`endif

endmodule

// ----- hw/rtl/rvp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvp_ctrl: sequencing state machine
// Loads the region, then steps the datapath through mean, deviation sum,
// square root, coefficient and priority.
// ----------------------------------------------------------------------------
module rvp_ctrl
    import rvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    input  rvp_stat_t st,
    output rvp_cmd_t  cmd
);

    localparam int SW = 5;
    localparam logic [SW-1:0] S_LOAD      = 5'd0;
    localparam logic [SW-1:0] S_MEAN_GO   = 5'd1;
    localparam logic [SW-1:0] S_MEAN_WAIT = 5'd2;
    localparam logic [SW-1:0] S_MEAN_TAKE = 5'd3;
    localparam logic [SW-1:0] S_ZERO      = 5'd4;
    localparam logic [SW-1:0] S_RD        = 5'd5;
    localparam logic [SW-1:0] S_DEV       = 5'd6;
    localparam logic [SW-1:0] S_SQ        = 5'd7;
    localparam logic [SW-1:0] S_ACC       = 5'd8;
    localparam logic [SW-1:0] S_VAR_GO    = 5'd9;
    localparam logic [SW-1:0] S_VAR_WAIT  = 5'd10;
    localparam logic [SW-1:0] S_VAR_TAKE  = 5'd11;
    localparam logic [SW-1:0] S_SQRT      = 5'd12;
    localparam logic [SW-1:0] S_NUM       = 5'd13;
    localparam logic [SW-1:0] S_DEN       = 5'd14;
    localparam logic [SW-1:0] S_CV_GO     = 5'd15;
    localparam logic [SW-1:0] S_CV_WAIT   = 5'd16;
    localparam logic [SW-1:0] S_CV_TAKE   = 5'd17;
    localparam logic [SW-1:0] S_ABS       = 5'd18;
    localparam logic [SW-1:0] S_PSAT      = 5'd19;
    localparam logic [SW-1:0] S_AA        = 5'd20;
    localparam logic [SW-1:0] S_LO        = 5'd21;
    localparam logic [SW-1:0] S_HI        = 5'd22;
    localparam logic [SW-1:0] S_P_GO      = 5'd23;
    localparam logic [SW-1:0] S_P_WAIT    = 5'd24;
    localparam logic [SW-1:0] S_P_TAKE    = 5'd25;
    localparam logic [SW-1:0] S_OUT       = 5'd26;

    logic [SW-1:0] state_reg;
    logic [SW-1:0] state_next;
    logic          accept;

    assign s_tready = state_reg == S_LOAD;
    assign accept   = s_tvalid && s_tready;

    // Next state and command for the datapath.
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.op = OP_LOAD;
                    if (s_tlast || st.count_full)
                    begin
                        state_next = S_MEAN_GO;
                    end
                end
            end
            S_MEAN_GO:
            begin
                cmd.op     = OP_MEAN_GO;
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (st.div_done)
                begin
                    state_next = S_MEAN_TAKE;
                end
            end
            S_MEAN_TAKE:
            begin
                cmd.op     = OP_MEAN_TAKE;
                state_next = st.mean_zero ? S_ZERO : S_RD;
            end
            S_ZERO:
            begin
                cmd.op     = OP_ZERO;
                state_next = S_OUT;
            end
            S_RD:
            begin
                cmd.op     = OP_RD;
                state_next = S_DEV;
            end
            S_DEV:
            begin
                cmd.op     = OP_DEV;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = st.idx_last ? S_VAR_GO : S_RD;
            end
            S_VAR_GO:
            begin
                if (st.single)
                begin
                    cmd.op     = OP_VAR_ZERO;
                    state_next = S_SQRT;
                end
                else
                begin
                    cmd.op     = OP_VAR_GO;
                    state_next = S_VAR_WAIT;
                end
            end
            S_VAR_WAIT:
            begin
                if (st.div_done)
                begin
                    state_next = S_VAR_TAKE;
                end
            end
            S_VAR_TAKE:
            begin
                cmd.op     = OP_VAR_TAKE;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (st.sqrt_last)
                begin
                    state_next = S_NUM;
                end
            end
            S_NUM:
            begin
                cmd.op     = OP_NUM;
                state_next = S_DEN;
            end
            S_DEN:
            begin
                cmd.op     = OP_DEN;
                state_next = S_CV_GO;
            end
            S_CV_GO:
            begin
                cmd.op     = OP_CV_GO;
                state_next = S_CV_WAIT;
            end
            S_CV_WAIT:
            begin
                if (st.div_done)
                begin
                    state_next = S_CV_TAKE;
                end
            end
            S_CV_TAKE:
            begin
                cmd.op     = OP_CV_TAKE;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                cmd.op     = OP_ABS;
                state_next = st.prio_sat ? S_PSAT : S_AA;
            end
            S_PSAT:
            begin
                cmd.op     = OP_PSAT;
                state_next = S_OUT;
            end
            S_AA:
            begin
                cmd.op     = OP_AA;
                state_next = S_LO;
            end
            S_LO:
            begin
                cmd.op     = OP_LO;
                state_next = S_HI;
            end
            S_HI:
            begin
                cmd.op     = OP_HI;
                state_next = S_P_GO;
            end
            S_P_GO:
            begin
                cmd.op     = OP_P_GO;
                state_next = S_P_WAIT;
            end
            S_P_WAIT:
            begin
                if (st.div_done)
                begin
                    state_next = S_P_TAKE;
                end
            end
            S_P_TAKE:
            begin
                cmd.op     = OP_P_TAKE;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/region_variation_priority.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_variation_priority: refinement priority of one grid region
// Collects the samples of a region and returns the unbiased coefficient of
// variation and the refinement priority in Q16.16.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                        Word contents (low bits first)
//  -------  -----------------------------  ------------------------------------
//  s        s_tvalid s_tready s_tdata      sample_value[31:0], cell_size[63:32]
//           s_tlast                        last_sample
//  m        m_tvalid m_tready m_tdata      region_priority[31:0],
//           m_tuser                        variation_coeff[63:32]; zero_mean
//  cfg      cfg_wr_en cfg_wr_data          domain_size
//
//  Loading accepts one sample word per cycle. Closing a region runs the
//  mean, variance, coefficient and priority divisions on the shared
//  80-step radix-2 divider, a square root, and a deviation pass that reads,
//  subtracts, squares and accumulates each sample. A single sample skips the
//  variance division, a saturated coefficient or a zero domain_size skips
//  the priority division and a zero mean ends after the first division.
//  Reset clears the control state and sets domain_size to 1.0; no clearing
//  pass is needed. A result waits in the output register while the next
//  region loads; the following region then holds until that word is taken.
//
module region_variation_priority
    import rvp_pkg::*;
#(
    parameter int POINTS = POINTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // sample_value[31:0], cell_size[63:32]
    input  logic [63:0]       s_tdata,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    // region_priority[31:0], variation_coeff[63:32]
    output logic [63:0]       m_tdata,
    // zero_mean[0]
    output logic [0:0]        m_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  logic              cfg_wr_en,
    input  logic [DATA_W-1:0] cfg_wr_data
);

    rvp_cmd_t  cmd;
    rvp_stat_t st;

    rvp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    rvp_datapath #(
        .POINTS (POINTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
